>>> rtl/column_gap_linear_fill_assert.svh
// assertion macros shared by the column gap fill checker
`ifndef COLUMN_GAP_LINEAR_FILL_ASSERT_SVH
`define COLUMN_GAP_LINEAR_FILL_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CGF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CGF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cgf_pkg.sv
// shared types and constants for the column gap fill block
`default_nettype none

package cgf_pkg;

  localparam int DEFAULT_MAX_LEVELS = 64;
  localparam int COMP_W             = 32;

  typedef struct packed {
    logic              gap;
    logic [COMP_W-1:0] c;
    logic [COMP_W-1:0] b;
    logic [COMP_W-1:0] a;
  } level_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_SRD,
    ST_SCHK,
    ST_MUL1,
    ST_MUL2,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/cgf_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module cgf_div import cgf_pkg::*; #(
  parameter int DW = 39,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               fin,
  output logic [DW-1:0]      quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VW-1:0]    rem;
  logic [VW:0]      shifted;
  logic [VW:0]      trial;

  assign shifted = {rem, quotient[DW-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      fin <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the trial top bit tells the sign
      if (!trial[VW]) begin
        rem      <= trial[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= shifted[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/column_gap_linear_fill.sv
// column gap fill: loads one column of vectors, emits it with gaps interpolated or held at top
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata a,b,c; tuser missing; tlast column end
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata a,b,c; tlast last level
//
// levels are loaded while the input is ready; the closing transfer starts emission and
// the input stays not ready until the last level has gone out.
// a valid level is read, checked and then offered on the output; a gap level runs
// the shared multiplier twice and the shared bit-serial divider once per component,
// after the next valid level has been searched at the start of a gap.
// reset is synchronous and clears the level count, the sequencer and the divider control only.
// output stalls simply hold the sequencer in its output state.
`default_nettype none

module column_gap_linear_fill import cgf_pkg::*; #(
  parameter int MAX_LEVELS = DEFAULT_MAX_LEVELS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [3*COMP_W-1:0] s_axis_tdata,  // comp_a, comp_b, comp_c
  input  wire logic                s_axis_tuser,  // is_missing
  input  wire logic                s_axis_tlast,  // column_end
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [3*COMP_W-1:0]      m_axis_tdata,  // fill_a, fill_b, fill_c
  output logic                     m_axis_tlast   // final_level
);

  localparam int AW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW    = $clog2(MAX_LEVELS + 1);
  localparam int NUM_W = COMP_W + CW;

  state_t state, state_next;

  level_t mem [MAX_LEVELS];
  level_t rdata;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] count;
  logic [AW-1:0] k;
  logic [CW-1:0] j;
  logic [AW-1:0] q;
  logic [CW-1:0] pp1;   // previous valid position plus one, zero below the bottom
  logic          have_next;
  logic          trailing;
  logic [1:0]    ci;

  logic signed [COMP_W-1:0] prev_a, prev_b, prev_c;
  logic signed [COMP_W-1:0] next_a, next_b, next_c;
  logic signed [COMP_W-1:0] res_a, res_b, res_c;
  logic                     res_last;

  logic signed [NUM_W-1:0]  acc;
  logic                     neg;

  logic                     in_xfer, out_xfer;
  logic                     k_last, k_end, j_end;
  logic [CW-1:0]            w_prev, w_next, span;
  logic signed [COMP_W-1:0] mul_x;
  logic [CW-1:0]            mul_w;
  logic signed [COMP_W+CW:0] prod;
  logic [NUM_W-1:0]         mag;
  logic                     div_start, div_fin;
  logic [NUM_W-1:0]         quo;
  logic [COMP_W-1:0]        quo_s;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  assign k_last = (CW'(k) + CW'(1)) == count;
  assign k_end  = k_last;                   // no level above k
  assign j_end  = (j + CW'(1)) == count;

  assign w_prev = CW'(q) - CW'(k);
  assign w_next = CW'(k) + CW'(1) - pp1;
  assign span   = CW'(q) + CW'(1) - pp1;

  // shared multiplier operands
  always_comb begin
    unique case (ci)
      2'd0:    mul_x = (state == ST_MUL1) ? prev_a : next_a;
      2'd1:    mul_x = (state == ST_MUL1) ? prev_b : next_b;
      default: mul_x = (state == ST_MUL1) ? prev_c : next_c;
    endcase
    mul_w = (state == ST_MUL1) ? w_prev : w_next;
  end

  assign prod = mul_x * $signed({1'b0, mul_w});
  assign mag  = neg ? NUM_W'(-acc) : NUM_W'(acc);
  assign quo_s = neg ? (COMP_W'(0) - quo[COMP_W-1:0]) : quo[COMP_W-1:0];

  cgf_div #(
    .DW (NUM_W),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (span),
    .fin      (div_fin),
    .quotient (quo)
  );

  // level store
  assign rd_addr = (state == ST_SRD) ? j[AW-1:0] : k;

  always_ff @(posedge clk) begin
    if (in_xfer && (count < CW'(MAX_LEVELS))) begin
      mem[count[AW-1:0]] <= '{gap: s_axis_tuser, c: s_axis_tdata[3*COMP_W-1:2*COMP_W],
                              b: s_axis_tdata[2*COMP_W-1:COMP_W],
                              a: s_axis_tdata[COMP_W-1:0]};
    end
    rdata <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_xfer && s_axis_tlast) state_next = ST_RD;
      ST_RD:     state_next = ST_CHK;
      ST_CHK: begin
        if (!rdata.gap || trailing) state_next = ST_OUT;
        else if (have_next)         state_next = ST_MUL1;
        else if (k_end)             state_next = ST_OUT;
        else                        state_next = ST_SRD;
      end
      ST_SRD:    state_next = ST_SCHK;
      ST_SCHK: begin
        if (!rdata.gap)  state_next = ST_MUL1;
        else if (j_end)  state_next = ST_OUT;
        else             state_next = ST_SRD;
      end
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT: begin
        if (div_fin) state_next = (ci == 2'd2) ? ST_OUT : ST_MUL1;
      end
      ST_OUT: begin
        if (out_xfer) state_next = k_last ? ST_IDLE : ST_RD;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_OUT);
    div_start     = (state == ST_DSTART);
  end

  assign m_axis_tdata = {res_c, res_b, res_a};
  assign m_axis_tlast = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (in_xfer && (count < CW'(MAX_LEVELS))) begin
        count <= count + CW'(1);
      end
      if (out_xfer && k_last) begin
        count <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        k         <= '0;
        pp1       <= '0;
        have_next <= 1'b0;
        trailing  <= 1'b0;
        prev_a    <= '0;
        prev_b    <= '0;
        prev_c    <= '0;
      end
      ST_CHK: begin
        res_last <= k_last;
        ci       <= 2'd0;
        if (!rdata.gap) begin
          res_a     <= rdata.a;
          res_b     <= rdata.b;
          res_c     <= rdata.c;
          prev_a    <= rdata.a;
          prev_b    <= rdata.b;
          prev_c    <= rdata.c;
          pp1       <= CW'(k) + CW'(1);
          have_next <= 1'b0;
        end else if (trailing || (!have_next && k_end)) begin
          // no valid level above: hold the last valid one
          trailing <= 1'b1;
          res_a    <= prev_a;
          res_b    <= prev_b;
          res_c    <= prev_c;
        end else begin
          j <= CW'(k) + CW'(1);
        end
      end
      ST_SCHK: begin
        if (!rdata.gap) begin
          next_a    <= rdata.a;
          next_b    <= rdata.b;
          next_c    <= rdata.c;
          q         <= j[AW-1:0];
          have_next <= 1'b1;
        end else if (j_end) begin
          trailing <= 1'b1;
          res_a    <= prev_a;
          res_b    <= prev_b;
          res_c    <= prev_c;
        end else begin
          j <= j + CW'(1);
        end
      end
      ST_MUL1: acc <= NUM_W'(prod);
      ST_MUL2: begin
        acc <= acc + NUM_W'(prod);
        neg <= acc[NUM_W-1] ^ prod[COMP_W+CW] ? (acc + NUM_W'(prod)) < 0
                                              : acc[NUM_W-1];
      end
      ST_DWAIT: begin
        if (div_fin) begin
          unique case (ci)
            2'd0:    res_a <= quo_s;
            2'd1:    res_b <= quo_s;
            default: res_c <= quo_s;
          endcase
          ci <= ci + 2'd1;
        end
      end
      ST_OUT: begin
        if (out_xfer && !k_last) begin
          k <= k + AW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/cgf_checker.sv
// port-level checker for the column gap fill block, bound to the top level
`default_nettype none

`include "column_gap_linear_fill_assert.svh"

module cgf_checker import cgf_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                s_axis_tlast,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [3*COMP_W-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  logic s_xfer, m_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  // loading and emitting never overlap
  `CGF_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid, "ready while emitting")

  // the closing transfer stops intake
  `CGF_ASSERT_NEXT(a_close_stops, s_xfer && s_axis_tlast, !s_axis_tready, "intake after close")

  // after the last level the block is ready for a new column
  `CGF_ASSERT_NEXT(a_last_frees, m_xfer && m_axis_tlast, s_axis_tready, "not ready after last")

  // a stalled result holds
  `CGF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
                   "stalled transfer changed")

endmodule

bind column_gap_linear_fill cgf_checker u_cgf_checker (.*);

`default_nettype wire
